### hdl/pipt_pkg.sv
// Shared types, constants and widths for the point-in-polygon tester.
`timescale 1ns / 1ps

package pipt_pkg;

  localparam int MAX_POINTS  = 256;
  localparam int COORD_BITS  = 16;
  localparam int MIN_VERTS   = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                          op;
    logic signed [COORD_BITS-1:0]  x;
    logic signed [COORD_BITS-1:0]  y;
  } cmd_t;

  typedef struct packed {
    logic vld;
    logic on;
    logic flip;
  } edge_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_RESULT
  } back_st_e;

endpackage

### hdl/point_in_polygon_tester.sv
// Top level of the point-in-polygon tester: command queue in front of the contour engine.
`timescale 1ns / 1ps

// Clear, append and query words enter a two-word queue and are executed in order by the
// back end. A query against n >= 3 stored vertices walks the vertex memory, reading one
// vertex per cycle (n + 1 reads, the closing edge first), then a three-stage edge pipeline
// drains and the answer moves into the output register. A query with fewer than three
// vertices answers outside. Appends past capacity are dropped and set the overflow flag
// reported with each query until the next clear. Action code 3 is accepted and ignored.
// The vertex memory is not cleared; only entries written since the last clear are read.
module point_in_polygon_tester (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             action_i,
  input  logic signed [pipt_pkg::COORD_BITS-1:0] coord_x_i,
  input  logic signed [pipt_pkg::COORD_BITS-1:0] coord_y_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   inside_res_o,
  output logic                                   overflowed_o
);
  import pipt_pkg::*;

  logic cmd_vld;
  cmd_t cmd;
  logic cmd_pop;

  pipt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .coord_x_i  (coord_x_i),
    .coord_y_i  (coord_y_i),
    .cmd_vld_o  (cmd_vld),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  pipt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_vld_i    (cmd_vld),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .inside_res_o (inside_res_o),
    .overflowed_o (overflowed_o)
  );

endmodule

### hdl/pipt_front.sv
// Input side: accepts words, drops unused codes, and queues commands for the back end.
`timescale 1ns / 1ps

module pipt_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           action_i,
  input  logic signed [pipt_pkg::COORD_BITS-1:0] coord_x_i,
  input  logic signed [pipt_pkg::COORD_BITS-1:0] coord_y_i,
  output logic                                 cmd_vld_o,
  output pipt_pkg::cmd_t                       cmd_o,
  input  logic                                 cmd_pop_i
);
  import pipt_pkg::*;

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              accept;
  logic              push;
  logic              pop;
  cmd_t              word;

  assign in_stall_o = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = accept && (action_i inside {CMD_CLEAR, CMD_APPEND, CMD_QUERY});
  assign cmd_vld_o  = (cnt_q != '0);
  assign pop        = cmd_pop_i && cmd_vld_o;
  assign cmd_o      = entry_q[rd_ptr_q];

  always_comb begin
    word.op = cmd_e'(action_i);
    word.x  = coord_x_i;
    word.y  = coord_y_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= word;
    end
  end

endmodule

### hdl/pipt_edge.sv
// Edge test pipeline: on-segment check and ray crossing for one edge per cycle.
`timescale 1ns / 1ps

module pipt_edge (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   vld_i,
  input  logic signed [pipt_pkg::COORD_BITS-1:0] ax_i,
  input  logic signed [pipt_pkg::COORD_BITS-1:0] ay_i,
  input  logic signed [pipt_pkg::COORD_BITS-1:0] bx_i,
  input  logic signed [pipt_pkg::COORD_BITS-1:0] by_i,
  input  logic signed [pipt_pkg::COORD_BITS-1:0] px_i,
  input  logic signed [pipt_pkg::COORD_BITS-1:0] py_i,
  output pipt_pkg::edge_res_t                    res_o,
  output logic                                   busy_o
);
  import pipt_pkg::*;

  logic                     a_vld_q;
  logic signed [DIFF_W-1:0] abx_q, aby_q, apx_q, apy_q;
  logic                     a_cross_q;

  logic                     b_vld_q;
  logic signed [PROD_W-1:0] m_apx_aby_q, m_apy_abx_q, m_apx_abx_q, m_apy_aby_q;
  logic signed [PROD_W-1:0] m_abx2_q, m_aby2_q;
  logic                     b_zero_q, b_at_a_q, b_cross_q, b_pos_q, b_neg_q;

  logic                     c_vld_q;
  logic signed [SUM_W-1:0]  side_q, dot_q, len2_q;
  logic                     c_zero_q, c_at_a_q, c_cross_q, c_pos_q, c_neg_q;

  logic                     seg_on;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    abx_q     <= DIFF_W'(bx_i) - DIFF_W'(ax_i);
    aby_q     <= DIFF_W'(by_i) - DIFF_W'(ay_i);
    apx_q     <= DIFF_W'(px_i) - DIFF_W'(ax_i);
    apy_q     <= DIFF_W'(py_i) - DIFF_W'(ay_i);
    a_cross_q <= (ay_i > py_i) != (by_i > py_i);

    m_apx_aby_q <= PROD_W'(apx_q) * PROD_W'(aby_q);
    m_apy_abx_q <= PROD_W'(apy_q) * PROD_W'(abx_q);
    m_apx_abx_q <= PROD_W'(apx_q) * PROD_W'(abx_q);
    m_apy_aby_q <= PROD_W'(apy_q) * PROD_W'(aby_q);
    m_abx2_q    <= PROD_W'(abx_q) * PROD_W'(abx_q);
    m_aby2_q    <= PROD_W'(aby_q) * PROD_W'(aby_q);
    b_zero_q    <= (abx_q == '0) && (aby_q == '0);
    b_at_a_q    <= (apx_q == '0) && (apy_q == '0);
    b_cross_q   <= a_cross_q;
    b_pos_q     <= !aby_q[DIFF_W-1] && (aby_q != '0);
    b_neg_q     <= aby_q[DIFF_W-1];

    side_q    <= SUM_W'(m_apx_aby_q) - SUM_W'(m_apy_abx_q);
    dot_q     <= SUM_W'(m_apx_abx_q) + SUM_W'(m_apy_aby_q);
    len2_q    <= SUM_W'(m_abx2_q) + SUM_W'(m_aby2_q);
    c_zero_q  <= b_zero_q;
    c_at_a_q  <= b_at_a_q;
    c_cross_q <= b_cross_q;
    c_pos_q   <= b_pos_q;
    c_neg_q   <= b_neg_q;
  end

  assign seg_on = (side_q == '0) && !dot_q[SUM_W-1] && (dot_q <= len2_q);

  always_comb begin
    res_o.vld  = c_vld_q;
    res_o.on   = c_zero_q ? c_at_a_q : seg_on;
    res_o.flip = c_cross_q &&
                 ((c_pos_q && side_q[SUM_W-1]) ||
                  (c_neg_q && !side_q[SUM_W-1] && (side_q != '0)));
  end

  assign busy_o = a_vld_q || b_vld_q || c_vld_q;

endmodule

### hdl/pipt_back.sv
// Back end: vertex memory, contour bookkeeping, edge walk sequencer and result register.
`timescale 1ns / 1ps

module pipt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_vld_i,
  input  pipt_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           inside_res_o,
  output logic           overflowed_o
);
  import pipt_pkg::*;

  back_st_e state_q, state_d;

  logic [COORD_BITS-1:0] mem_x [MAX_POINTS];
  logic [COORD_BITS-1:0] mem_y [MAX_POINTS];

  logic [CNT_W-1:0]  vcount_q;
  logic              ovf_q;
  logic [ADDR_W-1:0] addr_q;
  logic              first_q;
  logic              s1_vld_q, s1_first_q;
  logic signed [COORD_BITS-1:0] rd_x_q, rd_y_q;
  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic              on_q, par_q;
  logic              out_vld_q, inside_q, out_ovf_q;

  logic [CNT_W-1:0]  cnt_m1;
  logic [ADDR_W-1:0] last_addr;
  logic              pop;
  logic              issue;
  logic              load;
  logic              wr_en;
  logic              is_query;
  edge_res_t         edge_res;
  logic              edge_busy;

  assign cnt_m1    = vcount_q - CNT_W'(1);
  assign last_addr = cnt_m1[ADDR_W-1:0];
  assign is_query  = (cmd_i.op == CMD_QUERY);
  assign wr_en     = pop && (cmd_i.op == CMD_APPEND) && (vcount_q < CNT_W'(MAX_POINTS));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_vld_i && is_query) begin
          state_d = (vcount_q < CNT_W'(MIN_VERTS)) ? ST_RESULT : ST_WALK;
        end
      end
      ST_WALK: begin
        if (!first_q && (addr_q == last_addr)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !edge_busy) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_vld_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    issue = 1'b0;
    load  = 1'b0;
    case (state_q)
      ST_IDLE:   pop   = cmd_vld_i;
      ST_WALK:   issue = 1'b1;
      ST_RESULT: load  = !out_vld_q || !out_stall_i;
      default: ;
    endcase
  end

  assign cmd_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      vcount_q   <= '0;
      ovf_q      <= 1'b0;
      first_q    <= 1'b0;
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      s1_vld_q   <= issue;
      s1_first_q <= first_q;
      if (pop) begin
        case (cmd_i.op)
          CMD_CLEAR: begin
            vcount_q <= '0;
            ovf_q    <= 1'b0;
          end
          CMD_APPEND: begin
            if (wr_en) begin
              vcount_q <= vcount_q + CNT_W'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
          CMD_QUERY: first_q <= 1'b1;
          default: ;
        endcase
      end else if (issue) begin
        first_q <= 1'b0;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && is_query) begin
      px_q   <= cmd_i.x;
      py_q   <= cmd_i.y;
      addr_q <= last_addr;
      on_q   <= 1'b0;
      par_q  <= 1'b0;
    end else begin
      if (issue) begin
        addr_q <= first_q ? '0 : addr_q + ADDR_W'(1);
      end
      if (edge_res.vld) begin
        on_q  <= on_q | edge_res.on;
        par_q <= par_q ^ edge_res.flip;
      end
    end
    if (s1_vld_q) begin
      prev_x_q <= rd_x_q;
      prev_y_q <= rd_y_q;
    end
    if (load) begin
      inside_q  <= on_q | par_q;
      out_ovf_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[vcount_q[ADDR_W-1:0]] <= cmd_i.x;
      mem_y[vcount_q[ADDR_W-1:0]] <= cmd_i.y;
    end
    rd_x_q <= mem_x[addr_q];
    rd_y_q <= mem_y[addr_q];
  end

  pipt_edge u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s1_vld_q && !s1_first_q),
    .ax_i   (prev_x_q),
    .ay_i   (prev_y_q),
    .bx_i   (rd_x_q),
    .by_i   (rd_y_q),
    .px_i   (px_q),
    .py_i   (py_q),
    .res_o  (edge_res),
    .busy_o (edge_busy)
  );

  assign out_valid_o  = out_vld_q;
  assign inside_res_o = inside_q;
  assign overflowed_o = out_ovf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcount_q <= CNT_W'(MAX_POINTS))
    else $error("vertex count above capacity");

  a_edge_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_res.vld |-> (state_q == ST_WALK || state_q == ST_DRAIN))
    else $error("edge result outside a walk");

  a_load_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == ST_RESULT)
    else $error("result register loaded outside result state");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> !s1_vld_q && !edge_busy)
    else $error("command taken while an edge walk is in flight");

endmodule
